@@ hw/rtl/eia_pkg.sv @@
// shared types and codes of the entity id allocator
package eia_pkg;

    localparam logic [2:0] OP_AUTO_CREATE = 3'd0;
    localparam logic [2:0] OP_CREATE_AT   = 3'd1;
    localparam logic [2:0] OP_DESTROY     = 3'd2;
    localparam logic [2:0] OP_SET_SIG     = 3'd3;
    localparam logic [2:0] OP_GET_SIG     = 3'd4;
    localparam logic [2:0] OP_QUERY       = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ID     = 2'd1;
    localparam logic [1:0] ST_ALIVE     = 2'd2;
    localparam logic [1:0] ST_NOT_ALIVE = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  entity_id;
        logic [31:0] signature_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entity_id_out;
        logic [31:0] signature_out;
        logic        alive_out;
    } rsp_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctl_stat_t;

endpackage

@@ hw/rtl/eia_stream_if.sv @@
// valid/ready channel carrying one payload
interface eia_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/eia_ram.sv @@
// single write port, single registered read port memory
module eia_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ hw/rtl/eia_step_unit.sv @@
// shared increment/decrement and equality compare
module eia_step_unit #(
    parameter int W = 9
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         dec,
    output logic [W-1:0] sum,
    output logic         eq
);
    always_comb
    begin
        sum = dec ? (a - W'(1)) : (a + W'(1));
        eq  = (a == b);
    end
endmodule

@@ hw/rtl/eia_ctrl.sv @@
// allocator sequencer with free stack, entity table and shared step unit
module eia_ctrl #(
    parameter int NUM_IDS  = 256,
    parameter int SIG_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  eia_pkg::req_t      req,
    input  logic               slot_free,
    output eia_pkg::ctl_stat_t stat,
    output eia_pkg::rsp_t      rsp
);
    import eia_pkg::*;

    localparam int ID_W  = $clog2(NUM_IDS);
    localparam int CNT_W = $clog2(NUM_IDS + 1);
    localparam int ENT_W = SIG_BITS + 1;
    localparam logic [ENT_W-1:0] ENT_LIVE = {1'b1, {SIG_BITS{1'b0}}};
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_IDS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_IDS - 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_POP      = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_WALK_CHK = 4'd6;
    localparam logic [3:0] S_SEARCH   = 4'd7;
    localparam logic [3:0] S_SRCH_CHK = 4'd8;
    localparam logic [3:0] S_SHIFT_RD = 4'd9;
    localparam logic [3:0] S_SHIFT_WR = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                in_range_reg, in_range_next;
    logic [SIG_BITS-1:0] sig_reg, sig_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    fresh_reg, fresh_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    rsp_t                res_reg, res_next;
    logic                done_pulse;

    logic [CNT_W-1:0] unit_a, unit_b, unit_sum;
    logic             unit_dec, unit_eq;

    logic             ent_we, ent_re;
    logic [ID_W-1:0]  ent_waddr, ent_raddr;
    logic [ENT_W-1:0] ent_wdata, ent_rdata;
    logic             stk_we, stk_re;
    logic [ID_W-1:0]  stk_waddr, stk_raddr;
    logic [ID_W-1:0]  stk_wdata, stk_rdata;
    logic             ent_alive, stk_match;

    eia_step_unit #(.W(CNT_W)) u_step (
        .a   (unit_a),
        .b   (unit_b),
        .dec (unit_dec),
        .sum (unit_sum),
        .eq  (unit_eq)
    );

    eia_ram #(.DEPTH(NUM_IDS), .WIDTH(ENT_W)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    eia_ram #(.DEPTH(NUM_IDS), .WIDTH(ID_W)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign ent_alive = ent_rdata[SIG_BITS];
    assign stk_match = (stk_rdata == id_reg);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        in_range_next = in_range_reg;
        sig_next      = sig_reg;
        cnt_next      = cnt_reg;
        fresh_next    = fresh_reg;
        idx_next      = idx_reg;
        res_next      = res_reg;
        unit_a        = '0;
        unit_b        = '0;
        unit_dec      = 1'b0;
        ent_we        = 1'b0;
        ent_waddr     = '0;
        ent_wdata     = '0;
        ent_re        = 1'b0;
        ent_raddr     = '0;
        stk_we        = 1'b0;
        stk_waddr     = '0;
        stk_wdata     = '0;
        stk_re        = 1'b0;
        stk_raddr     = '0;
        done_pulse    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = idx_reg[ID_W-1:0];
                unit_a    = idx_reg;
                unit_b    = CNT_LAST;
                if (unit_eq)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = unit_sum;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = req.opcode;
                    id_next       = ID_W'(req.entity_id);
                    in_range_next = (32'(req.entity_id) < 32'(NUM_IDS));
                    sig_next      = SIG_BITS'(req.signature_in);
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next = '0;
                unique case (op_reg)
                    OP_AUTO_CREATE:
                    begin
                        unit_a   = cnt_reg;
                        unit_dec = 1'b1;
                        if (unit_eq)
                        begin
                            state_next = S_WALK;
                        end
                        else
                        begin
                            stk_re     = 1'b1;
                            stk_raddr  = unit_sum[ID_W-1:0];
                            cnt_next   = unit_sum;
                            state_next = S_POP;
                        end
                    end
                    OP_CREATE_AT, OP_DESTROY, OP_SET_SIG, OP_GET_SIG, OP_QUERY:
                    begin
                        if (in_range_reg)
                        begin
                            ent_re     = 1'b1;
                            ent_raddr  = id_reg;
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            if (op_reg == OP_CREATE_AT)
                            begin
                                res_next.status = ST_NO_ID;
                            end
                            else if (op_reg != OP_QUERY)
                            begin
                                res_next.status = ST_NOT_ALIVE;
                            end
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP:
            begin
                ent_we                 = 1'b1;
                ent_waddr              = stk_rdata;
                ent_wdata              = ENT_LIVE;
                res_next.entity_id_out = 8'(stk_rdata);
                res_next.alive_out     = 1'b1;
                state_next             = S_DONE;
            end
            S_WALK:
            begin
                unit_a = fresh_reg;
                unit_b = CNT_FULL;
                if (unit_eq)
                begin
                    res_next.status = ST_NO_ID;
                    state_next      = S_DONE;
                end
                else
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = fresh_reg[ID_W-1:0];
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                unit_a     = fresh_reg;
                fresh_next = unit_sum;
                if (ent_alive)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    ent_we                 = 1'b1;
                    ent_waddr              = fresh_reg[ID_W-1:0];
                    ent_wdata              = ENT_LIVE;
                    res_next.entity_id_out = 8'(fresh_reg);
                    res_next.alive_out     = 1'b1;
                    state_next             = S_DONE;
                end
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_CREATE_AT:
                    begin
                        res_next.alive_out = 1'b1;
                        if (ent_alive)
                        begin
                            res_next.status = ST_ALIVE;
                        end
                        else
                        begin
                            ent_we                 = 1'b1;
                            ent_waddr              = id_reg;
                            ent_wdata              = ENT_LIVE;
                            res_next.entity_id_out = 8'(id_reg);
                            unit_a                 = cnt_reg;
                            if (!unit_eq)
                            begin
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                    end
                    OP_DESTROY:
                    begin
                        if (!ent_alive)
                        begin
                            res_next.status = ST_NOT_ALIVE;
                        end
                        else
                        begin
                            ent_we    = 1'b1;
                            ent_waddr = id_reg;
                            unit_a    = cnt_reg;
                            unit_b    = CNT_FULL;
                            if (!unit_eq)
                            begin
                                stk_we    = 1'b1;
                                stk_waddr = cnt_reg[ID_W-1:0];
                                stk_wdata = id_reg;
                                cnt_next  = unit_sum;
                            end
                        end
                    end
                    OP_SET_SIG:
                    begin
                        if (!ent_alive)
                        begin
                            res_next.status = ST_NOT_ALIVE;
                        end
                        else
                        begin
                            ent_we             = 1'b1;
                            ent_waddr          = id_reg;
                            ent_wdata          = {1'b1, sig_reg};
                            res_next.alive_out = 1'b1;
                        end
                    end
                    OP_GET_SIG:
                    begin
                        if (!ent_alive)
                        begin
                            res_next.status = ST_NOT_ALIVE;
                        end
                        else
                        begin
                            res_next.signature_out = 32'(ent_rdata[SIG_BITS-1:0]);
                            res_next.alive_out     = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        res_next.alive_out = ent_alive;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                unit_a = idx_reg;
                unit_b = cnt_reg;
                if (unit_eq)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    stk_re     = 1'b1;
                    stk_raddr  = idx_reg[ID_W-1:0];
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                unit_dec = stk_match;
                unit_a   = stk_match ? cnt_reg : idx_reg;
                if (stk_match)
                begin
                    cnt_next   = unit_sum;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    idx_next   = unit_sum;
                    state_next = S_SEARCH;
                end
            end
            S_SHIFT_RD:
            begin
                unit_a = idx_reg;
                unit_b = cnt_reg;
                if (unit_eq)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    stk_re     = 1'b1;
                    stk_raddr  = unit_sum[ID_W-1:0];
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                stk_we     = 1'b1;
                stk_waddr  = idx_reg[ID_W-1:0];
                stk_wdata  = stk_rdata;
                unit_a     = idx_reg;
                idx_next   = unit_sum;
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    done_pulse = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = done_pulse;
    assign rsp       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            fresh_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        in_range_reg <= in_range_next;
        sig_reg      <= sig_next;
        res_reg      <= res_next;
    end
endmodule

@@ hw/rtl/entity_id_allocator_core.sv @@
// entity id allocator top level with request and response channels
//
// Hands out entity ids 0 to NUM_IDS-1 from a LIFO free stack, falling back
// to a next-fresh counter that skips ids already alive, and keeps an alive
// bit and a SIG_BITS-wide signature per id. One request is taken at a time;
// req.ready is high only while the sequencer is idle, and a finished response
// waits in an output register so the next request can be taken meanwhile.
// Set, get, query and destroy read the entity table and then update it or
// answer; an out-of-range id or an unused opcode is answered without a table
// read. An auto create pops the free stack, or, when that is empty, walks the
// next-fresh counter past each alive id until it finds a free id or runs out.
// A create at a given id with a non-empty free stack searches the stack for
// that id and, if found, moves each later entry down to close the gap, all
// through the free stack's single read and write ports and the one shared
// increment/compare unit. A response that is not taken holds the sequencer
// until the output register frees up. After reset a clearing pass over all
// NUM_IDS entries zeroes the entity table; no request is taken until it ends.
module entity_id_allocator_core #(
    parameter int NUM_IDS  = 256,
    parameter int SIG_BITS = 32
) (
    input logic         clk,
    input logic         rst_n,
    eia_stream_if.sink   req,
    eia_stream_if.source rsp
);
    import eia_pkg::*;

    ctl_stat_t ctl_stat;
    rsp_t      ctl_rsp;
    logic      rsp_valid_reg;
    rsp_t      rsp_data_reg;
    logic      slot_free;
    logic      start;
    req_t      req_data;

    assign req_data  = req.payload;
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign start     = req.valid && ctl_stat.idle;
    assign req.ready = ctl_stat.idle;

    eia_ctrl #(.NUM_IDS(NUM_IDS), .SIG_BITS(SIG_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req_data),
        .slot_free (slot_free),
        .stat      (ctl_stat),
        .rsp       (ctl_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl_stat.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_stat.done)
        begin
            rsp_data_reg <= ctl_rsp;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_stat.done |-> (!rsp_valid_reg || rsp.ready))
        else $error("response overwritten before it was taken");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(ctl_stat.done))
        else $error("response raised without a finished request");
`endif
endmodule

@@ sim/tb_top.sv @@
// self-checking testbench of the entity id allocator with a request driver and a response monitor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eia_pkg::*;

    localparam int NUM_IDS = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam int STALL_AT = 350;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    typedef enum int unsigned {MODE_MIXED, MODE_GROW, MODE_SHRINK} traffic_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    eia_stream_if #(.payload_t(req_t)) req_if ();
    eia_stream_if #(.payload_t(rsp_t)) rsp_if ();

    logic req_valid = 1'b0;
    req_t req_data = '0;
    logic rsp_rdy = 1'b0;

    assign req_if.valid = req_valid;
    assign req_if.payload = req_data;
    assign rsp_if.ready = rsp_rdy;

    entity_id_allocator_core #(
        .NUM_IDS (NUM_IDS),
        .SIG_BITS(32)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    req_t request_queue[$];
    rsp_t answer_queue[$];
    int unsigned errors = 0;

    function automatic void add_request(req_t r);
        request_queue = {request_queue, r};
    endfunction

    // allocator state as the block should hold it
    logic [7:0]  free_ids [NUM_IDS];
    int          free_depth;
    int          fresh_next;
    bit          live [NUM_IDS];
    logic [31:0] sig_tab [NUM_IDS];

    function automatic rsp_t predict_allocation(req_t r);
        rsp_t o;
        bit hit;
        int n;
        o = '0;
        n = r.entity_id;
        case (r.opcode)
            OP_AUTO_CREATE:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    o.entity_id_out = free_ids[free_depth];
                    live[free_ids[free_depth]] = 1'b1;
                    o.alive_out = 1'b1;
                end
                else
                begin
                    hit = 1'b0;
                    while (!hit && fresh_next < NUM_IDS)
                    begin
                        if (!live[fresh_next])
                        begin
                            live[fresh_next] = 1'b1;
                            o.entity_id_out = 8'(fresh_next);
                            hit = 1'b1;
                        end
                        fresh_next++;
                    end
                    if (hit)
                        o.alive_out = 1'b1;
                    else
                        o.status = ST_NO_ID;
                end
            end
            OP_CREATE_AT:
            begin
                if (live[n])
                begin
                    o.status = ST_ALIVE;
                    o.alive_out = 1'b1;
                end
                else
                begin
                    // pull the id out of the free stack, keeping the order of the rest
                    hit = 1'b0;
                    for (int k = 0; k < NUM_IDS; k++)
                    begin
                        if (!hit && k < free_depth && free_ids[k] == r.entity_id)
                            hit = 1'b1;
                        if (hit && k + 1 < free_depth)
                            free_ids[k] = free_ids[k + 1];
                    end
                    if (hit)
                        free_depth--;
                    live[n] = 1'b1;
                    o.entity_id_out = r.entity_id;
                    o.alive_out = 1'b1;
                end
            end
            OP_DESTROY:
            begin
                if (!live[n])
                    o.status = ST_NOT_ALIVE;
                else
                begin
                    sig_tab[n] = '0;
                    if (free_depth < NUM_IDS)
                    begin
                        free_ids[free_depth] = r.entity_id;
                        free_depth++;
                    end
                    live[n] = 1'b0;
                end
            end
            OP_SET_SIG:
            begin
                if (!live[n])
                    o.status = ST_NOT_ALIVE;
                else
                begin
                    sig_tab[n] = r.signature_in;
                    o.alive_out = 1'b1;
                end
            end
            OP_GET_SIG:
            begin
                if (!live[n])
                    o.status = ST_NOT_ALIVE;
                else
                begin
                    o.signature_out = sig_tab[n];
                    o.alive_out = 1'b1;
                end
            end
            OP_QUERY:
                o.alive_out = live[n];
            default:
                o = '0;
        endcase
        return o;
    endfunction

    function automatic req_t make_request(logic [2:0] op, logic [7:0] id, logic [31:0] sig);
        req_t r;
        r.opcode = op;
        r.entity_id = id;
        r.signature_in = sig;
        return r;
    endfunction

    function automatic req_t random_request(traffic_t mode);
        req_t r;
        int unsigned roll;
        int unsigned t_auto;
        int unsigned t_create;
        int unsigned t_destroy;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
            begin
                t_auto = 50;
                t_create = 62;
                t_destroy = 68;
            end
            MODE_SHRINK:
            begin
                t_auto = 5;
                t_create = 10;
                t_destroy = 55;
            end
            default:
            begin
                t_auto = 15;
                t_create = 30;
                t_destroy = 45;
            end
        endcase
        if ($urandom_range(0, 1) != 0)
            r.entity_id = 8'($urandom_range(0, 15));
        else
            r.entity_id = 8'($urandom_range(0, 255));
        r.signature_in = $urandom;
        if (roll < t_auto)
            r.opcode = OP_AUTO_CREATE;
        else if (roll < t_create)
            r.opcode = OP_CREATE_AT;
        else if (roll < t_destroy)
            r.opcode = OP_DESTROY;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                r.opcode = OP_SET_SIG;
            else if (roll < 60)
                r.opcode = OP_GET_SIG;
            else if (roll < 95)
                r.opcode = OP_QUERY;
            else if (roll < 98)
                r.opcode = OP_RSVD_A;
            else
                r.opcode = OP_RSVD_B;
        end
        return r;
    endfunction

    // runs of calm traffic alternate with runs of random waits
    function automatic int unsigned next_gap(inout int unsigned run_left, inout bit quiet);
        if (run_left == 0)
        begin
            run_left = $urandom_range(1, 40);
            quiet = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    int unsigned src_wait;
    int unsigned src_run = 0;
    bit          src_quiet = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            src_wait <= 0;
            free_depth = 0;
            fresh_next = 0;
            for (int i = 0; i < NUM_IDS; i++)
            begin
                live[i] = 1'b0;
                sig_tab[i] = '0;
            end
        end
        else
        begin
            if (req_valid && req_if.ready)
                answer_queue = {answer_queue, predict_allocation(req_data)};
            if (!req_valid || req_if.ready)
            begin
                if (src_wait != 0)
                begin
                    src_wait <= src_wait - 1;
                    req_valid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_data <= request_queue.pop_front();
                    src_wait <= next_gap(src_run, src_quiet);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    int unsigned sink_wait;
    int unsigned sink_run = 0;
    bit          sink_quiet = 1'b0;
    int unsigned answers_seen;
    int unsigned stall_left;
    bit          stall_used;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        rsp_t got;
        int unsigned w;
        if (!rst_n)
        begin
            rsp_rdy <= 1'b0;
            sink_wait <= 0;
            answers_seen <= 0;
            stall_left <= 0;
            stall_used <= 1'b0;
        end
        else
        begin
            w = sink_wait;
            if (rsp_if.valid && rsp_rdy)
            begin
                got = rsp_if.payload;
                answers_seen <= answers_seen + 1;
                w = next_gap(sink_run, sink_quiet);
                if (answer_queue.size() == 0)
                begin
                    $display("%0t: response with no request outstanding: %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.entity_id_out !== want.entity_id_out)
                    begin
                        $display("%0t: entity_id_out expected %0d actual %0d",
                                 $time, want.entity_id_out, got.entity_id_out);
                        errors++;
                    end
                    if (got.signature_out !== want.signature_out)
                    begin
                        $display("%0t: signature_out expected %h actual %h",
                                 $time, want.signature_out, got.signature_out);
                        errors++;
                    end
                    if (got.alive_out !== want.alive_out)
                    begin
                        $display("%0t: alive_out expected %0d actual %0d",
                                 $time, want.alive_out, got.alive_out);
                        errors++;
                    end
                end
            end
            // one long back-pressure stretch while requests keep coming
            if (!stall_used && answers_seen == STALL_AT)
            begin
                stall_used <= 1'b1;
                stall_left <= STALL_CYCLES;
                rsp_rdy <= 1'b0;
                sink_wait <= w;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rsp_rdy <= 1'b0;
                sink_wait <= w;
            end
            else if (w != 0)
            begin
                sink_wait <= w - 1;
                rsp_rdy <= 1'b0;
            end
            else
            begin
                sink_wait <= 0;
                rsp_rdy <= 1'b1;
            end
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_rdy))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [7:0] order [NUM_IDS];
        logic [7:0] t;
        int unsigned j;
        traffic_t mode;

        add_request(make_request(OP_QUERY, 8'd0, 32'h0));
        add_request(make_request(OP_GET_SIG, 8'd0, 32'h0));
        add_request(make_request(OP_DESTROY, 8'd255, 32'h0));
        add_request(make_request(OP_SET_SIG, 8'd7, 32'hFFFF_FFFF));
        add_request(make_request(OP_AUTO_CREATE, 8'd0, 32'h0));
        add_request(make_request(OP_AUTO_CREATE, 8'd255, 32'hFFFF_FFFF));
        add_request(make_request(OP_CREATE_AT, 8'd255, 32'h0));
        add_request(make_request(OP_CREATE_AT, 8'd255, 32'h0));
        add_request(make_request(OP_SET_SIG, 8'd255, 32'hFFFF_FFFF));
        add_request(make_request(OP_GET_SIG, 8'd255, 32'h0));
        add_request(make_request(OP_SET_SIG, 8'd0, 32'h0));
        add_request(make_request(OP_GET_SIG, 8'd0, 32'hFFFF_FFFF));
        add_request(make_request(OP_CREATE_AT, 8'd2, 32'h0));
        add_request(make_request(OP_AUTO_CREATE, 8'd0, 32'h0));
        add_request(make_request(OP_DESTROY, 8'd1, 32'h0));
        add_request(make_request(OP_DESTROY, 8'd255, 32'h0));
        add_request(make_request(OP_CREATE_AT, 8'd1, 32'h0));
        add_request(make_request(OP_AUTO_CREATE, 8'd0, 32'h0));
        add_request(make_request(OP_GET_SIG, 8'd255, 32'h0));
        add_request(make_request(OP_QUERY, 8'd255, 32'h0));
        add_request(make_request(OP_QUERY, 8'd200, 32'h0));
        add_request(make_request(OP_RSVD_A, 8'd255, 32'hFFFF_FFFF));
        add_request(make_request(OP_RSVD_B, 8'd0, 32'h0));
        add_request(make_request(OP_SET_SIG, 8'd3, 32'hA5A5_5A5A));
        add_request(make_request(OP_GET_SIG, 8'd3, 32'h0));

        for (int e = 0; e < 6; e++)
        begin
            mode = (e == 0) ? MODE_GROW : traffic_t'($urandom_range(0, 2));
            for (int i = 0; i < 100; i++)
                add_request(random_request(mode));
        end

        // run the pool dry, then fill the free stack completely
        for (int i = 0; i < 300; i++)
            add_request(make_request(OP_AUTO_CREATE, 8'($urandom_range(0, 255)), $urandom));
        for (int i = 0; i < 30; i++)
        begin
            j = $urandom_range(0, 255);
            add_request(make_request(OP_SET_SIG, 8'(j), $urandom));
            add_request(make_request(OP_GET_SIG, 8'(j), $urandom));
        end
        for (int i = 0; i < NUM_IDS; i++)
            order[i] = 8'(i);
        for (int i = NUM_IDS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < NUM_IDS; i++)
            add_request(make_request(OP_DESTROY, order[i], $urandom));
        for (int i = 0; i < 30; i++)
        begin
            j = $urandom_range(0, 255);
            add_request(make_request(OP_CREATE_AT, 8'(j), $urandom));
            add_request(make_request(OP_GET_SIG, 8'(j), $urandom));
        end

        for (int e = 0; e < 4; e++)
        begin
            mode = traffic_t'($urandom_range(0, 2));
            for (int i = 0; i < 100; i++)
                add_request(random_request(mode));
        end

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || req_valid || answer_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ entity_id_allocator_core.f @@
hw/rtl/eia_pkg.sv
hw/rtl/eia_stream_if.sv
hw/rtl/eia_ram.sv
hw/rtl/eia_step_unit.sv
hw/rtl/eia_ctrl.sv
hw/rtl/entity_id_allocator_core.sv
sim/tb_top.sv
